// File: design/spi_register_file_slave_top_assert.svh
// ----------------------------------------------------------------------------
// SPI register file slave assertion macros
// Concurrent assertion forms for the register file slave control module.
// ----------------------------------------------------------------------------
`ifndef SPI_REGISTER_FILE_SLAVE_TOP_ASSERT_SVH
`define SPI_REGISTER_FILE_SLAVE_TOP_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define SRF_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("srf check failed: same-cycle implication");

// Next-cycle implication, skipped while reset is high.
`define SRF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("srf check failed: next-cycle implication");

`endif

// File: design/srf_pkg.sv
// ----------------------------------------------------------------------------
// SPI register file slave package
// Constants, command codes, default register contents and the RAM request.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int REG_COUNT = 256;
  localparam int ADDR_W    = $clog2(REG_COUNT);
  localparam int DATA_W    = 8;

  // Item kinds carried in tuser
  localparam logic CMD_CS   = 1'b0;
  localparam logic CMD_XFER = 1'b1;

  // Chip select level that selects the device
  localparam logic CS_ACTIVE = 1'b0;

  localparam int READ_BIT = 7;

  localparam logic [DATA_W-1:0] ADDR_BYTE_MASK   = 8'h7F;
  localparam logic [ADDR_W-1:0] ADDR_SOFT_RESET  = 8'h6B;
  localparam logic [DATA_W-1:0] SOFT_RESET_VALUE = 8'h80;
  localparam logic [ADDR_W-1:0] SOFT_RESET_PTR   = 8'h01;

  localparam logic [REG_COUNT-1:0] SOFT_RESET_MASK =
    {{(REG_COUNT-1){1'b0}}, 1'b1} << ADDR_SOFT_RESET;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } srf_ram_req_t;

  // Power-on contents of the register file
  function automatic logic [DATA_W-1:0] default_value(input logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] val;
    unique case (addr)
      8'h75:   val = 8'hAF;
      8'h6B:   val = 8'h01;
      8'h3B:   val = 8'h01;
      8'h3C:   val = 8'h02;
      8'h3D:   val = 8'h03;
      8'h3E:   val = 8'h04;
      8'h3F:   val = 8'h05;
      8'h40:   val = 8'h06;
      8'h41:   val = 8'h10;
      8'h42:   val = 8'h00;
      8'h43:   val = 8'h11;
      8'h44:   val = 8'h22;
      8'h45:   val = 8'h33;
      8'h46:   val = 8'h44;
      8'h47:   val = 8'h55;
      8'h48:   val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: design/srf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/srf_ctrl.sv
// ----------------------------------------------------------------------------
// SPI register file slave control
// Select/address/read/write sequencing, pointer, and written-entry tracking.
// ----------------------------------------------------------------------------
`include "spi_register_file_slave_top_assert.svh"

module srf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          cmd,
  input  logic                          cs_level,
  input  logic [srf_pkg::DATA_W-1:0]    mosi_byte,
  input  logic [srf_pkg::DATA_W-1:0]    ram_rdata,
  output srf_pkg::srf_ram_req_t         ram_req,
  output logic [srf_pkg::DATA_W-1:0]    miso_byte
);

  import srf_pkg::*;

  logic              selected, selected_next;
  logic              await_address, await_address_next;
  logic              read_mode, read_mode_next;
  logic [ADDR_W-1:0] pointer, pointer_next;
  logic [REG_COUNT-1:0] written;
  logic              soft_reset;
  logic              is_read;
  logic [DATA_W-1:0] rd_value;

  // Entries never written since the last reset read as their defaults
  assign rd_value = written[pointer] ? ram_rdata : default_value(pointer);

  always_comb begin
    selected_next      = selected;
    await_address_next = await_address;
    read_mode_next     = read_mode;
    pointer_next       = pointer;
    soft_reset         = 1'b0;
    is_read            = 1'b0;
    miso_byte          = '0;
    ram_req.we         = 1'b0;
    ram_req.waddr      = pointer;
    ram_req.wdata      = mosi_byte;
    if (accept) begin
      if (cmd == CMD_CS) begin
        selected_next      = (cs_level == CS_ACTIVE);
        await_address_next = 1'b1;
      end else if (selected) begin
        if (await_address) begin
          await_address_next = 1'b0;
          read_mode_next     = mosi_byte[READ_BIT];
          pointer_next       = mosi_byte & ADDR_BYTE_MASK;
        end else if (read_mode) begin
          is_read      = 1'b1;
          miso_byte    = rd_value;
          pointer_next = pointer + 1'b1;
        end else begin
          ram_req.we = 1'b1;
          if (pointer == ADDR_SOFT_RESET && mosi_byte == SOFT_RESET_VALUE) begin
            soft_reset     = 1'b1;
            selected_next  = 1'b0;
            read_mode_next = 1'b0;
            pointer_next   = SOFT_RESET_PTR;
          end else begin
            pointer_next = pointer + 1'b1;
          end
        end
      end
    end
    // Read one step ahead so the registered data lines up with the pointer
    ram_req.raddr = rst ? '0 : pointer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected      <= 1'b0;
      await_address <= 1'b0;
      read_mode     <= 1'b0;
      pointer       <= '0;
      written       <= '0;
    end else begin
      selected      <= selected_next;
      await_address <= await_address_next;
      read_mode     <= read_mode_next;
      pointer       <= pointer_next;
      if (soft_reset) begin
        written <= SOFT_RESET_MASK;
      end else if (ram_req.we) begin
        written[pointer] <= 1'b1;
      end
    end
  end

  `SRF_ASSERT_NEXT(a_cs_arms, clk, rst, accept && cmd == CMD_CS, await_address)
  `SRF_ASSERT_NEXT(a_desel_hold, clk, rst, accept && cmd == CMD_XFER && !selected, $stable(pointer) && $stable(read_mode) && $stable(written))
  `SRF_ASSERT_NEXT(a_soft_reset, clk, rst, soft_reset, pointer == SOFT_RESET_PTR && !selected && !read_mode && written == SOFT_RESET_MASK)
  `SRF_ASSERT_NOW(a_miso_zero, clk, rst, !is_read, miso_byte == '0)

endmodule

// File: design/spi_register_file_slave_top.sv
// ----------------------------------------------------------------------------
// SPI register file slave, top level
// Byte-level SPI slave over a 256-entry register file with auto-increment.
// ----------------------------------------------------------------------------
//   channel  | dir | tdata                         | tuser
//   ---------+-----+-------------------------------+-------------------------
//   s_*      | in  | [0] cs_level, [8:1] mosi_byte | [0] cmd (0 select, 1 byte)
//   m_*      | out | [7:0] miso_byte               | -
//
// One item per cycle while the output is not stalled: every item (select event or byte) yields one result.
// The pointer decode and register read run between the input handshake and
// the output register; the RAM read is issued one item ahead at the next
// pointer, so there is no read bubble.
// Reset clears the control state and the written-entry flags at once; no
// clearing pass is needed, unwritten entries read as their default values.
// s_tready follows m_tready when a result is pending, so a stalled output
// stalls the input; an item is accepted in the same cycle a result is taken.
// ----------------------------------------------------------------------------
module spi_register_file_slave_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] cs_level, [8:1] mosi_byte, [15:9] zero
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] miso_byte
);

  import srf_pkg::*;

  logic                 accept;
  logic [DATA_W-1:0]    miso_byte;
  logic [DATA_W-1:0]    ram_rdata;
  srf_ram_req_t         ram_req;

  // Take a new item whenever the result register is free or being drained
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  srf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (s_tuser[0]),
    .cs_level  (s_tdata[0]),
    .mosi_byte (s_tdata[8:1]),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .miso_byte (miso_byte)
  );

  srf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= miso_byte;
    end
  end

endmodule
